>>> hdl/pwmc_pkg.sv
// Shared types, register map and reset values for the PWM register channel.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package pwmc_pkg;

  // Bus actions carried in s_tuser
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;
  localparam logic [1:0] ACT_TICK  = 2'd3;

  // Register map
  localparam logic [7:0] ADDR_MODE     = 8'h00;
  localparam logic [7:0] ADDR_ON_LO    = 8'h06;
  localparam logic [7:0] ADDR_ON_HI    = 8'h07;
  localparam logic [7:0] ADDR_OFF_LO   = 8'h08;
  localparam logic [7:0] ADDR_OFF_HI   = 8'h09;
  localparam logic [7:0] ADDR_PRESCALE = 8'hFE;

  localparam int          SLEEP_BIT      = 4;
  localparam logic [7:0]  MODE_RESET     = 8'h11;
  localparam logic [7:0]  PRESCALE_RESET = 8'h1E;
  localparam int          COUNTER_BITS_DEFAULT = 12;

  localparam int REG_DEPTH = 256;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } reg_write_t;

  // Reset contents of one register byte
  function automatic logic [7:0] reset_value(input logic [7:0] addr);
    logic [7:0] v;
    v = 8'h00;
    if (addr == ADDR_MODE) v = MODE_RESET;
    if (addr == ADDR_PRESCALE) v = PRESCALE_RESET;
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hdl/pwm_controller_register_channel.sv
// Top level of the PWM register channel: bus pointer logic, output register.
// Instantiates pwmc_regfile and pwmc_channel; uses pwmc_pkg.
//
// Usage:
//   Input channel s_*: one item per bus event. s_tuser carries the action
//   (write byte, read byte, bus stop, oscillator tick), s_tdata the byte.
//   Output channel m_*: exactly one item per input item, in order, with the
//   read byte (zero unless the action was a read) and the PWM pin level
//   after that item.
//   Timing: the result is registered and appears in the cycle after the input
//   is accepted; the register store read goes through its registered port.
//   Throughput: one item per cycle while the receiver keeps up.
//   Stall: the output register holds its item while m_tready is low, and
//   s_tready drops until it is taken; nothing is lost or reordered.
//   Reset: rst clears pointer, counter, divider and level at once, then a
//   clearing pass over all 256 addresses loads the store (mode 0x11,
//   prescale 0x1E, everything else zero); s_tready stays low during that pass.
//   The pin stays low after reset until mode is written with sleep clear.
`timescale 1ns / 1ps
`default_nettype none

module pwm_controller_register_channel #(
  parameter int COUNTER_BITS = pwmc_pkg::COUNTER_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data
  input  wire logic [1:0]  s_tuser,   // [1:0] action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // [7:0] read_data, [8] pwm_level, [15:9] zero
);
  import pwmc_pkg::*;

  logic       accept;
  logic       store_ready;
  logic [7:0] pointer;
  logic       expect_pointer;
  logic       read_q;
  logic [7:0] rd_data;
  logic       rd_en;
  logic       tick;
  logic       level;
  reg_write_t wr;

  assign s_tready = store_ready && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    wr.en   = accept && (s_tuser == ACT_WRITE) && !expect_pointer;
    wr.addr = pointer;
    wr.data = s_tdata;
  end
  assign rd_en = accept && (s_tuser == ACT_READ);
  assign tick  = accept && (s_tuser == ACT_TICK);

  // pointer: first written byte after reset or a stop loads it, reads/writes advance it
  always_ff @(posedge clk) begin
    if (rst) begin
      pointer        <= 8'h00;
      expect_pointer <= 1'b1;
    end else if (accept) begin
      case (s_tuser)
        ACT_WRITE: begin
          if (expect_pointer) begin
            pointer        <= s_tdata;
            expect_pointer <= 1'b0;
          end else begin
            pointer <= pointer + 8'd1;
          end
        end
        ACT_READ: pointer <= pointer + 8'd1;
        ACT_STOP: expect_pointer <= 1'b1;
        default: ;
      endcase
    end
  end

  // output register; level and read data only move on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) read_q <= (s_tuser == ACT_READ);
  end

  assign m_tdata = {7'b0, level, read_q ? rd_data : 8'h00};

  pwmc_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (pointer),
    .rd_data (rd_data),
    .ready   (store_ready)
  );

  pwmc_channel #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_channel (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .tick  (tick),
    .level (level)
  );

endmodule

`default_nettype wire

>>> hdl/pwmc_regfile.sv
// 256 x 8 register store: synchronous memory with a registered read port.
// Runs a clearing pass after reset that loads the reset values. Uses pwmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwmc_regfile (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pwmc_pkg::reg_write_t wr,
  input  wire logic               rd_en,
  input  wire logic [7:0]         rd_addr,
  output logic [7:0]              rd_data,
  output logic                    ready
);
  import pwmc_pkg::*;

  logic [7:0] mem [REG_DEPTH];
  logic       clearing;
  logic [7:0] clr_addr;
  logic       mem_we;
  logic [7:0] mem_waddr;
  logic [7:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= 8'h00;
    end else if (clearing) begin
      clr_addr <= clr_addr + 8'd1;
      if (clr_addr == 8'hFF) clearing <= 1'b0;
    end
  end

  always_comb begin
    mem_we    = clearing | wr.en;
    mem_waddr = clearing ? clr_addr : wr.addr;
    mem_wdata = clearing ? reset_value(clr_addr) : wr.data;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  assign ready = ~clearing;

endmodule

`default_nettype wire

>>> hdl/pwmc_channel.sv
// PWM channel: tick divider, counter, on/off compare and output level.
// Keeps shadow copies of mode, prescale and the on/off words. Uses pwmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwmc_channel #(
  parameter int COUNTER_BITS = pwmc_pkg::COUNTER_BITS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire pwmc_pkg::reg_write_t wr,
  input  wire logic                 tick,
  output logic                      level
);
  import pwmc_pkg::*;

  logic [7:0]              mode;
  logic [7:0]              prescale;
  logic [15:0]             on_word;
  logic [15:0]             off_word;
  logic [7:0]              divider;
  logic [COUNTER_BITS-1:0] counter;
  logic                    step;
  logic                    on_hit;
  logic                    off_hit;

  assign step    = tick && (divider >= prescale) && !mode[SLEEP_BIT];
  assign on_hit  = (16'(counter) == on_word);
  assign off_hit = (16'(counter) == off_word);

  // shadow registers track store writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_RESET;
      prescale <= PRESCALE_RESET;
      on_word  <= 16'h0000;
      off_word <= 16'h0000;
    end else if (wr.en) begin
      unique case (wr.addr)
        ADDR_MODE:     mode           <= wr.data;
        ADDR_PRESCALE: prescale       <= wr.data;
        ADDR_ON_LO:    on_word[7:0]   <= wr.data;
        ADDR_ON_HI:    on_word[15:8]  <= wr.data;
        ADDR_OFF_LO:   off_word[7:0]  <= wr.data;
        ADDR_OFF_HI:   off_word[15:8] <= wr.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divider <= 8'h00;
      counter <= '0;
      level   <= 1'b0;
    end else begin
      if (wr.en && (wr.addr == ADDR_MODE || wr.addr == ADDR_PRESCALE)) begin
        divider <= 8'h00;
      end else if (tick) begin
        divider <= (divider >= prescale) ? 8'h00 : divider + 8'd1;
      end
      if (step) begin
        counter <= counter + COUNTER_BITS'(1);
        if (off_hit) level <= 1'b0;
        else if (on_hit) level <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/pwmc_checker.sv
// Port-level checker for pwm_controller_register_channel, bound to the top.
// Uses pwmc_pkg for action codes.
`timescale 1ns / 1ps
`default_nettype none

module pwmc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [1:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);
  import pwmc_pkg::*;

  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output item dropped while stalled");

  // every accepted item yields a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("no result after accepted item");

  // read byte is zero for any action but a read
  a_rd_zero: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser != ACT_READ |=> m_tdata[7:0] == 8'h00)
    else $error("nonzero read_data for a non-read item");

  // only ticks move the pin
  a_level: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser != ACT_TICK |=> m_tdata[8] == $past(m_tdata[8]))
    else $error("pwm level changed on a bus action");

  // no item taken in the cycle after reset (clearing pass)
  a_clear: assert property (@(posedge clk)
    $fell(rst) |-> !s_tready)
    else $error("input ready during clearing pass");

endmodule

bind pwm_controller_register_channel pwmc_checker u_pwmc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
